// File: sv/apf_pkg.sv
// ----------------------------------------------------------------------------
// apf_pkg
// Shared types and constants for the articulation point finder.
// ----------------------------------------------------------------------------
package apf_pkg;

  localparam int MAX_NODES = 32;
  localparam int NODE_W    = 5;
  localparam int CNT_W     = 6;
  localparam int TIME_W    = 5;
  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(MAX_NODES);

  // one saved stack frame of the depth-first walk
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] par;
    logic [CNT_W-1:0]  nxt;
    logic [TIME_W-1:0] low;
    logic [TIME_W-1:0] disc;
  } frame_t;

  typedef struct packed {
    logic idle;
    logic emit_init;
    logic root_enter;
    logic root_skip;
    logic push_enter;
    logic advance;
    logic rd_disc;
    logic low_from_disc;
    logic finish_root;
    logic rd_frame;
    logic pop_frame;
    logic emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic last_fire;
    logic root_end;
    logic root_visited;
    logic scan_end;
    logic top_last;
    logic cand;
    logic v_visited;
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

// File: sv/apf_ram.sv
// ----------------------------------------------------------------------------
// apf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module apf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// File: sv/apf_ctrl.sv
// ----------------------------------------------------------------------------
// apf_ctrl
// Sequencer for edge loading, the depth-first walk and the result run.
// ----------------------------------------------------------------------------
module apf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  apf_pkg::status_t st,
  output apf_pkg::cmd_t    cmd
);
  import apf_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ROOT  = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_VCHK  = 7'b0001000,
    ST_POPW  = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_CLEAR = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.idle = 1'b1;
        if (st.last_fire) state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (st.root_end) begin
          cmd.emit_init = 1'b1;
          state_nxt     = ST_EMIT;
        end else if (st.root_visited) begin
          cmd.root_skip = 1'b1;
        end else begin
          cmd.root_enter = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st.scan_end) begin
          if (st.top_last) begin
            cmd.finish_root = 1'b1;
            state_nxt       = ST_ROOT;
          end else begin
            cmd.rd_frame = 1'b1;
            state_nxt    = ST_POPW;
          end
        end else if (!st.cand) begin
          cmd.advance = 1'b1;
        end else if (!st.v_visited) begin
          cmd.push_enter = 1'b1;
        end else begin
          cmd.rd_disc = 1'b1;
          state_nxt   = ST_VCHK;
        end
      end
      ST_VCHK: begin
        cmd.low_from_disc = 1'b1;
        state_nxt         = ST_SCAN;
      end
      ST_POPW: begin
        cmd.pop_frame = 1'b1;
        state_nxt     = ST_SCAN;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.emit_last) state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a pop read is always followed by the frame restore
  a_pop_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_frame |=> cmd.pop_frame) else $error("pop restore missing");

  // loading only happens while idle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st.last_fire |-> state_r == ST_IDLE) else $error("load outside idle");

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> cmd.idle) else $error("clear not followed by idle");

endmodule

// File: sv/apf_datapath.sv
// ----------------------------------------------------------------------------
// apf_datapath
// Adjacency matrix, walk registers, stack and time memories, result register.
// ----------------------------------------------------------------------------
module apf_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  apf_pkg::cmd_t              cmd,
  output apf_pkg::status_t           st,
  input  logic [apf_pkg::CNT_W-1:0]  node_count,
  input  logic                       in_valid,
  input  logic [apf_pkg::NODE_W-1:0] in_node_a,
  input  logic [apf_pkg::NODE_W-1:0] in_node_b,
  input  logic                       in_edge_valid,
  input  logic                       in_last_edge,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [apf_pkg::NODE_W-1:0] out_node_index,
  output logic                       out_is_cut_vertex,
  output logic                       out_last_node
);
  import apf_pkg::*;

  logic [MAX_NODES-1:0] adj_r [MAX_NODES];
  logic [MAX_NODES-1:0] visited_r;
  logic [MAX_NODES-1:0] cut_r;
  logic [NODE_W-1:0]    u_r, par_r, root_r;
  logic [CNT_W-1:0]     nxt_r, depth_r, idx_r;
  logic [TIME_W-1:0]    low_r, disc_r;
  logic [CNT_W-1:0]     vcount_r;
  logic [1:0]           rootch_r;
  logic                 out_valid_r, out_cut_r, out_last_r;
  logic [NODE_W-1:0]    out_idx_r;

  logic [CNT_W-1:0]  n;
  logic              fire;
  logic [NODE_W-1:0] v;
  logic [NODE_W-1:0] idx;
  logic [CNT_W-1:0]  depth_m1, depth_m2;

  frame_t            push_frame, pop_f;
  logic              disc_we;
  logic [NODE_W-1:0] disc_waddr;
  logic [TIME_W-1:0] disc_rdata;

  // clamp node count into 1..MAX_NODES
  always_comb begin
    if (node_count == '0) begin
      n = CNT_W'(1);
    end else if (node_count > CNT_W'(MAX_NODES)) begin
      n = CNT_W'(MAX_NODES);
    end else begin
      n = node_count;
    end
  end

  assign fire     = in_valid && cmd.idle;
  assign v        = nxt_r[NODE_W-1:0];
  assign idx      = idx_r[NODE_W-1:0];
  assign depth_m1 = depth_r - CNT_W'(1);
  assign depth_m2 = depth_r - CNT_W'(2);

  assign st.last_fire    = fire && in_last_edge;
  assign st.root_end     = idx_r >= n;
  assign st.root_visited = visited_r[idx];
  assign st.scan_end     = nxt_r >= n;
  assign st.top_last     = depth_r == CNT_W'(1);
  assign st.cand         = adj_r[u_r][v] && (v != u_r) &&
                           !((depth_r > CNT_W'(1)) && (v == par_r));
  assign st.v_visited    = visited_r[v];
  assign st.out_free     = !out_valid_r || !out_stall;
  assign st.emit_last    = idx_r == (n - CNT_W'(1));

  assign push_frame.node = u_r;
  assign push_frame.par  = par_r;
  assign push_frame.nxt  = nxt_r + CNT_W'(1);
  assign push_frame.low  = low_r;
  assign push_frame.disc = disc_r;

  assign disc_we    = cmd.root_enter || cmd.push_enter;
  assign disc_waddr = cmd.root_enter ? idx : v;

  apf_ram #(.WIDTH($bits(frame_t)), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk   (clk),
    .we    (cmd.push_enter),
    .waddr (depth_m1[NODE_W-1:0]),
    .wdata (push_frame),
    .re    (cmd.rd_frame),
    .raddr (depth_m2[NODE_W-1:0]),
    .rdata (pop_f)
  );

  apf_ram #(.WIDTH(TIME_W), .DEPTH(MAX_NODES)) u_disc_ram (
    .clk   (clk),
    .we    (disc_we),
    .waddr (disc_waddr),
    .wdata (vcount_r[TIME_W-1:0]),
    .re    (cmd.rd_disc),
    .raddr (v),
    .rdata (disc_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        adj_r[i] <= '0;
      end
      visited_r <= '0;
      cut_r     <= '0;
      depth_r   <= '0;
      vcount_r  <= '0;
      rootch_r  <= '0;
      idx_r     <= '0;
    end else begin
      if (fire && in_edge_valid && (CNT_W'(in_node_a) < n) && (CNT_W'(in_node_b) < n)) begin
        adj_r[in_node_a][in_node_b] <= 1'b1;
        adj_r[in_node_b][in_node_a] <= 1'b1;
      end
      if (st.last_fire || cmd.emit_init) begin
        idx_r <= '0;
      end
      if (cmd.root_skip || cmd.emit) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.root_enter) begin
        visited_r[idx] <= 1'b1;
        u_r      <= idx;
        par_r    <= idx;
        root_r   <= idx;
        nxt_r    <= '0;
        low_r    <= vcount_r[TIME_W-1:0];
        disc_r   <= vcount_r[TIME_W-1:0];
        vcount_r <= vcount_r + CNT_W'(1);
        depth_r  <= CNT_W'(1);
        rootch_r <= '0;
      end
      if (cmd.push_enter) begin
        visited_r[v] <= 1'b1;
        u_r      <= v;
        par_r    <= u_r;
        nxt_r    <= '0;
        low_r    <= vcount_r[TIME_W-1:0];
        disc_r   <= vcount_r[TIME_W-1:0];
        vcount_r <= vcount_r + CNT_W'(1);
        depth_r  <= depth_r + CNT_W'(1);
        if (depth_r == CNT_W'(1) && rootch_r != 2'd2) begin
          rootch_r <= rootch_r + 2'd1;
        end
      end
      if (cmd.advance || cmd.rd_disc) begin
        nxt_r <= nxt_r + CNT_W'(1);
      end
      if (cmd.low_from_disc && (disc_rdata < low_r)) begin
        low_r <= disc_rdata;
      end
      if (cmd.finish_root) begin
        depth_r <= '0;
        if (rootch_r > 2'd1) cut_r[root_r] <= 1'b1;
      end
      if (cmd.pop_frame) begin
        u_r     <= pop_f.node;
        par_r   <= pop_f.par;
        nxt_r   <= pop_f.nxt;
        low_r   <= (low_r < pop_f.low) ? low_r : pop_f.low;
        disc_r  <= pop_f.disc;
        depth_r <= depth_m1;
        // child subtree cannot reach above the parent
        if (depth_r > CNT_W'(2) && low_r >= pop_f.disc) begin
          cut_r[pop_f.node] <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r  <= idx;
      out_cut_r  <= cut_r[idx];
      out_last_r <= st.emit_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_node_index    = out_idx_r;
  assign out_is_cut_vertex = out_cut_r;
  assign out_last_node     = out_last_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CNT_W'(MAX_NODES)) else $error("stack depth overflow");

  a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_frame |-> depth_r > CNT_W'(1)) else $error("pop of root frame");

  a_push_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_enter |-> !visited_r[v]) else $error("revisit of node");

  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (visited_r == '0 && cut_r == '0)) else $error("flags not cleared");

endmodule

// File: sv/articulation_point_finder.sv
// loading: edge beats are taken only while idle (in_stall low); the final beat starts the walk
// walk: one adjacency bit per cycle of the top stack frame, plus an ST_VCHK step
//   for each visited neighbor and an ST_POPW step for each pop of a frame
// results: n beats, one per cycle when out_stall is low; ST_CLEAR then wipes the graph
// reset: synchronous active-low rst_n clears the graph, flags and counters
//   and sets node_count to 32; no clearing pass is needed
// ----------------------------------------------------------------------------
// articulation_point_finder
// Finds the cut vertices of an undirected graph loaded one edge per beat.
// ----------------------------------------------------------------------------
module articulation_point_finder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [1:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [apf_pkg::NODE_W-1:0] in_node_a,
  input  logic [apf_pkg::NODE_W-1:0] in_node_b,
  input  logic                       in_edge_valid,
  input  logic                       in_last_edge,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [apf_pkg::NODE_W-1:0] out_node_index,
  output logic                       out_is_cut_vertex,
  output logic                       out_last_node
);
  import apf_pkg::*;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;

  logic [CNT_W-1:0] node_count_r;
  cmd_t             cmd;
  status_t          st;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_NODE_COUNT)) begin
      node_count_r <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata   = {{(32-CNT_W){1'b0}}, node_count_r};
  assign in_stall = !cmd.idle;

  apf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  apf_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .node_count        (node_count_r),
    .in_valid          (in_valid),
    .in_node_a         (in_node_a),
    .in_node_b         (in_node_b),
    .in_edge_valid     (in_edge_valid),
    .in_last_edge      (in_last_edge),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_node_index    (out_node_index),
    .out_is_cut_vertex (out_is_cut_vertex),
    .out_last_node     (out_last_node)
  );

endmodule
